[sv/bvfm_pkg.sv]
package bvfm_pkg;

	localparam int unsigned MV_W    = 16;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned SUM_W   = 22;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 3;

	// One quotient bit per divider step, over the full width of the sum.
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam logic [STAT_W-1:0] STATUS_NORMAL = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_UNDER  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_OVER   = 2'd2;

	localparam logic [IDX_W-1:0] REG_OVER_THRESHOLD  = 3'd0;
	localparam logic [IDX_W-1:0] REG_UNDER_THRESHOLD = 3'd1;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS      = 3'd2;
	localparam logic [IDX_W-1:0] REG_RECOVER_DELAY   = 3'd3;

	localparam logic [MV_W-1:0]   RST_OVER_THRESHOLD  = 16'd32000;
	localparam logic [MV_W-1:0]   RST_UNDER_THRESHOLD = 16'd8000;
	localparam logic [MV_W-1:0]   RST_HYSTERESIS      = 16'd2000;
	localparam logic [TICK_W-1:0] RST_RECOVER_DELAY   = 32'd3000;

	typedef struct packed {
		logic [MV_W-1:0]   sample_mv;
		logic              has_sample;
		logic              batch_end;
		logic [TICK_W-1:0] now_ticks;
	} item_t;

	typedef struct packed {
		logic [MV_W-1:0]   voltage_mv;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic eval_write;
	} ctl_cmd_t;

	typedef struct packed {
		logic result_free;
	} dp_stat_t;

endpackage

[sv/bus_voltage_fault_monitor.sv]
// Bus voltage monitor: samples in millivolts are summed into a batch of up to
// MAX_BATCH samples (extra samples are dropped), and an item with batch_end
// closes the batch, averages it with a truncating divide (an empty batch keeps
// the last average) and updates the normal / undervoltage / overvoltage state
// with hysteresis and a recovery delay counted on now_ticks. Only batch-end
// items produce a result. An item without batch_end is taken whenever the
// block is idle, back to back. A batch-end item holds the input while the
// bit-serial restoring divider runs (one quotient bit per cycle over the 22-bit
// sum), while the result is evaluated and loaded into the result register, and
// while the previous result still sits stalled there. Configuration registers are
// written through cfg_we, cfg_index and cfg_data while the block is idle, as
// the user must ensure, unenforced by the block; unknown indexes are ignored.
module bus_voltage_fault_monitor #(
	parameter int unsigned MAX_BATCH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  bvfm_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bvfm_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [bvfm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bvfm_pkg::CFG_W-1:0]    cfg_data
);
	import bvfm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bvfm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.batch_end  (item.batch_end),
		.item_stall (item_stall),
		.cmd        (cmd),
		.stat       (stat)
	);

	bvfm_dpath #(
		.MAX_BATCH (MAX_BATCH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[sv/bvfm_ctrl.sv]
module bvfm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                batch_end,
	output logic                item_stall,
	output bvfm_pkg::ctl_cmd_t  cmd,
	input  bvfm_pkg::dp_stat_t  stat
);
	import bvfm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cmd.accept     = accept;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.eval_write = (state_q == ST_EVAL) && stat.result_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && batch_end) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_EVAL;
					end
					step_q <= step_q + 1'b1;
				end
				ST_EVAL: begin
					if (stat.result_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/bvfm_dpath.sv]
module bvfm_dpath #(
	parameter int unsigned MAX_BATCH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvfm_pkg::item_t               item,
	input  bvfm_pkg::ctl_cmd_t            cmd,
	output bvfm_pkg::dp_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [bvfm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bvfm_pkg::CFG_W-1:0]    cfg_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bvfm_pkg::result_t             result
);
	import bvfm_pkg::*;

	logic [MV_W-1:0]   over_q;
	logic [MV_W-1:0]   under_q;
	logic [MV_W-1:0]   hyst_q;
	logic [TICK_W-1:0] delay_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [MV_W-1:0]   avg_q;
	logic [STAT_W-1:0] fault_q;
	logic              wait_q;
	logic [TICK_W-1:0] start_q;

	// Restoring divider state; the dividend shifts out as quotient bits shift in.
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  divisor_q;
	logic              div_en_q;
	logic [TICK_W-1:0] now_q;

	logic              add_ok;
	logic [SUM_W-1:0]  sum_nx;
	logic [CNT_W-1:0]  count_nx;
	logic [CNT_W:0]    shifted;
	logic              fits;
	logic [CNT_W:0]    trial;

	logic [MV_W-1:0]   avg_nx;
	logic [MV_W:0]     over_level;
	logic [MV_W:0]     under_level;
	logic              recovered;
	logic [TICK_W-1:0] elapsed;
	logic [STAT_W-1:0] fault_nx;
	logic              wait_nx;
	logic [TICK_W-1:0] start_nx;

	assign add_ok   = item.has_sample && (count_q < CNT_W'(MAX_BATCH));
	assign sum_nx   = add_ok ? sum_q + SUM_W'(item.sample_mv) : sum_q;
	assign count_nx = add_ok ? count_q + 1'b1 : count_q;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = (shifted >= {1'b0, divisor_q});
	assign trial   = shifted - {1'b0, divisor_q};

	assign stat.result_free = !result_valid || !result_stall;

	always_comb begin
		avg_nx      = div_en_q ? quo_q[MV_W-1:0] : avg_q;
		over_level  = {1'b0, over_q} - {1'b0, hyst_q};
		under_level = {1'b0, under_q} + {1'b0, hyst_q};
		elapsed     = now_q - start_q;
		// With the margin larger than the over threshold nothing can lie below it.
		if (fault_q == STATUS_OVER) begin
			recovered = (over_q >= hyst_q) && ({1'b0, avg_nx} < over_level);
		end else begin
			recovered = ({1'b0, avg_nx} > under_level);
		end
		fault_nx = fault_q;
		wait_nx  = wait_q;
		start_nx = start_q;
		if (fault_q != STATUS_NORMAL) begin
			if (recovered) begin
				if (!wait_q) begin
					wait_nx  = 1'b1;
					start_nx = now_q;
				end else if (elapsed >= delay_q) begin
					fault_nx = STATUS_NORMAL;
					wait_nx  = 1'b0;
				end
			end else begin
				wait_nx = 1'b0;
			end
		end else if (avg_nx > over_q) begin
			fault_nx = STATUS_OVER;
		end else if (avg_nx < under_q) begin
			fault_nx = STATUS_UNDER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q  <= RST_OVER_THRESHOLD;
			under_q <= RST_UNDER_THRESHOLD;
			hyst_q  <= RST_HYSTERESIS;
			delay_q <= RST_RECOVER_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OVER_THRESHOLD:  over_q  <= cfg_data[MV_W-1:0];
				REG_UNDER_THRESHOLD: under_q <= cfg_data[MV_W-1:0];
				REG_HYSTERESIS:      hyst_q  <= cfg_data[MV_W-1:0];
				REG_RECOVER_DELAY:   delay_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			count_q      <= '0;
			avg_q        <= '0;
			fault_q      <= STATUS_NORMAL;
			wait_q       <= 1'b0;
			start_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (item.batch_end) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nx;
					count_q <= count_nx;
				end
			end
			if (cmd.eval_write) begin
				avg_q        <= avg_nx;
				fault_q      <= fault_nx;
				wait_q       <= wait_nx;
				start_q      <= start_nx;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.batch_end) begin
			quo_q     <= sum_nx;
			rem_q     <= '0;
			divisor_q <= count_nx;
			div_en_q  <= (count_nx != '0);
			now_q     <= item.now_ticks;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
		if (cmd.eval_write) begin
			result.voltage_mv <= avg_nx;
			result.status     <= fault_nx;
		end
	end

endmodule

[dv/bus_voltage_fault_monitor_test.sv]
`timescale 1ns / 1ps

module bus_voltage_fault_monitor_test;
	import bvfm_pkg::*;

	localparam int BATCH_LIMIT  = 32;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	// Copy of the monitor's registers and state, advanced on every accepted item.
	logic [MV_W-1:0]   cfg_over;
	logic [MV_W-1:0]   cfg_under;
	logic [MV_W-1:0]   cfg_hyst;
	logic [TICK_W-1:0] cfg_delay;
	logic [SUM_W-1:0]  batch_sum;
	logic [CNT_W-1:0]  batch_count;
	logic [MV_W-1:0]   avg_mv;
	logic [STAT_W-1:0] fault_state;
	bit                recover_wait;
	logic [TICK_W-1:0] recover_from;

	result_t expected_results[$];
	result_t predicted;
	result_t oldest;
	int      mismatch_count;
	bit      sender_idle_on;
	bit      recv_idle_on;
	int      stall_hold_left;

	bus_voltage_fault_monitor #(
		.MAX_BATCH(BATCH_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic item_t make_item(input logic [MV_W-1:0] mv, input logic has,
			input logic fin, input logic [TICK_W-1:0] now);
		item_t it;
		it.sample_mv  = mv;
		it.has_sample = has;
		it.batch_end  = fin;
		it.now_ticks  = now;
		return it;
	endfunction

	function automatic logic [MV_W-1:0] clip_mv(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return MV_W'(v);
	endfunction

	// Accumulates one item into the batch; on a batch end it averages, updates the
	// fault state and returns 1 with the result the monitor must produce.
	function automatic bit fold_item(input item_t it, output result_t res);
		int                level;
		bit                back_in_range;
		logic [TICK_W-1:0] elapsed;
		res = '0;
		if (it.has_sample && batch_count < BATCH_LIMIT) begin
			batch_sum   = batch_sum + it.sample_mv;
			batch_count = batch_count + 1'b1;
		end
		if (!it.batch_end)
			return 1'b0;
		if (batch_count != 0)
			avg_mv = MV_W'(batch_sum / batch_count);
		batch_sum   = '0;
		batch_count = '0;
		level = int'(avg_mv);
		if (fault_state != STATUS_NORMAL) begin
			// The recovery level may go negative, so compare in signed arithmetic.
			if (fault_state == STATUS_OVER)
				back_in_range = level < int'(cfg_over) - int'(cfg_hyst);
			else
				back_in_range = level > int'(cfg_under) + int'(cfg_hyst);
			if (!back_in_range) begin
				recover_wait = 1'b0;
			end else if (!recover_wait) begin
				recover_wait = 1'b1;
				recover_from = it.now_ticks;
			end else begin
				elapsed = it.now_ticks - recover_from;
				if (elapsed >= cfg_delay) begin
					fault_state  = STATUS_NORMAL;
					recover_wait = 1'b0;
				end
			end
		end else if (avg_mv > cfg_over) begin
			fault_state = STATUS_OVER;
		end else if (avg_mv < cfg_under) begin
			fault_state = STATUS_UNDER;
		end
		res.voltage_mv = avg_mv;
		res.status     = fault_state;
		return 1'b1;
	endfunction

	function automatic int pick_level();
		int over;
		int under;
		int hyst;
		over  = int'(cfg_over);
		under = int'(cfg_under);
		hyst  = int'(cfg_hyst);
		case ($urandom_range(5))
			0: return int'($urandom_range(0, under));
			1: return under + int'($urandom_range(0, hyst + 2));
			2: return int'($urandom_range(under, over));
			3: return over - int'($urandom_range(0, hyst + 2));
			4: return int'($urandom_range(over, 65535));
			default: return int'($urandom_range(0, 65535));
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_hold_left != 0) begin
			result_stall <= 1'b1;
			stall_hold_left <= stall_hold_left - 1;
		end else begin
			result_stall <= recv_idle_on && ($urandom_range(99) < 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			if (fold_item(item, predicted))
				expected_results.push_back(predicted);
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result voltage_mv=%0d status=%0d", $time,
					result.voltage_mv, result.status);
				mismatch_count++;
			end else begin
				oldest = expected_results.pop_front();
				if (result.voltage_mv !== oldest.voltage_mv) begin
					$display("%0t: voltage_mv expected %0d actual %0d", $time,
						oldest.voltage_mv, result.voltage_mv);
					mismatch_count++;
				end
				if (result.status !== oldest.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						oldest.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	// Offers one transaction and returns at the edge where it is taken.
	task automatic send_item(input item_t it);
		while (sender_idle_on && ($urandom_range(99) < 16)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// The extra edge lets the checker record a transaction taken at the last edge.
	task automatic wait_for_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Upper data bits of the 16-bit registers are random and must be dropped;
	// the last write goes to an unused index and must change nothing.
	task automatic program_regs(input logic [MV_W-1:0] over, input logic [MV_W-1:0] under,
			input logic [MV_W-1:0] hyst, input logic [TICK_W-1:0] delay);
		wait_for_idle();
		write_reg(REG_OVER_THRESHOLD, {16'($urandom), over});
		write_reg(REG_UNDER_THRESHOLD, {16'($urandom), under});
		write_reg(REG_HYSTERESIS, {16'($urandom), hyst});
		write_reg(REG_RECOVER_DELAY, delay);
		write_reg(IDX_W'(REG_RECOVER_DELAY + 1 + $urandom_range(0, 3)), $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_over  = over;
		cfg_under = under;
		cfg_hyst  = hyst;
		cfg_delay = delay;
	endtask

	task automatic run_random_phase(input int n_items, input int max_step);
		int                sent;
		int                len;
		int                lvl;
		int                k;
		bit                joined;
		logic [TICK_W-1:0] tick;
		tick = $urandom;
		sent = 0;
		while (sent < n_items) begin
			// Mostly short batches, now and then a long one that may run past the batch limit.
			len = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
			lvl = pick_level();
			joined = (len != 0) && ($urandom_range(1) == 1);
			if ($urandom_range(15) == 0)
				tick = $urandom;
			else
				tick = tick + $urandom_range(0, max_step);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(11) == 0)
					send_item(make_item(16'($urandom), 1'b0, 1'b0, $urandom));
				send_item(make_item(clip_mv(lvl + int'($urandom_range(0, 16)) - 8), 1'b1,
					joined && (k == len - 1), (joined && (k == len - 1)) ? tick : $urandom));
				sent++;
			end
			if (!joined) begin
				send_item(make_item(16'($urandom), 1'b0, 1'b1, tick));
				sent++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		// Empty batch right after reset averages to zero and trips undervoltage.
		send_item(make_item(16'd0, 1'b0, 1'b1, 32'd100));
		send_item(make_item(16'd20000, 1'b1, 1'b0, 32'd200));
		send_item(make_item(16'd20000, 1'b1, 1'b1, 32'd300));
		send_item(make_item(16'd0, 1'b0, 1'b1, 32'd3299));
		send_item(make_item(16'd0, 1'b0, 1'b1, 32'd3300));
		send_item(make_item(16'hFFFF, 1'b1, 1'b1, 32'd4000));
		send_item(make_item(16'd29000, 1'b1, 1'b1, 32'd5000));
		// A rise back above the recovery level cancels the recovery wait.
		send_item(make_item(16'd31000, 1'b1, 1'b1, 32'd6000));
		// The wait below straddles the tick wrap.
		send_item(make_item(16'd29999, 1'b1, 1'b1, 32'hFFFF_FF00));
		send_item(make_item(16'd29999, 1'b1, 1'b1, 32'h0000_0AB3));
		send_item(make_item(16'd29999, 1'b1, 1'b1, 32'h0000_0BB8));
		send_item(make_item(16'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_item(make_item(16'hFFFF, 1'b0, 1'b0, 32'd0));
		send_item(make_item(16'd1, 1'b1, 1'b1, 32'd7001));
		send_item(make_item(16'd10000, 1'b1, 1'b1, 32'd8000));
	endtask

	task automatic test_register_extremes();
		program_regs(16'd40000, 16'd1000, 16'd0, 32'd0);
		send_item(make_item(16'd50000, 1'b1, 1'b1, 32'd10));
		send_item(make_item(16'd39999, 1'b1, 1'b1, 32'd10));
		send_item(make_item(16'd39999, 1'b1, 1'b1, 32'd10));
		send_item(make_item(16'd999, 1'b1, 1'b1, 32'd11));
		send_item(make_item(16'd1000, 1'b1, 1'b1, 32'd12));
		send_item(make_item(16'd1001, 1'b1, 1'b1, 32'd13));
		send_item(make_item(16'd1001, 1'b1, 1'b1, 32'd13));
		program_regs(16'd40000, 16'd1000, 16'd0, 32'hFFFF_FFFF);
		send_item(make_item(16'd50000, 1'b1, 1'b1, 32'd10));
		send_item(make_item(16'd39999, 1'b1, 1'b1, 32'd20));
		send_item(make_item(16'd39999, 1'b1, 1'b1, 32'd18));
		send_item(make_item(16'd39999, 1'b1, 1'b1, 32'd19));
		program_regs(16'hFFFF, 16'd0, 16'hFFFF, 32'd0);
		send_item(make_item(16'hFFFF, 1'b1, 1'b1, 32'd30));
		send_item(make_item(16'd0, 1'b1, 1'b1, 32'd31));
		// Hysteresis larger than the over level: this overvoltage cannot clear.
		program_regs(16'd0, 16'd0, 16'hFFFF, 32'd0);
		send_item(make_item(16'd1, 1'b1, 1'b1, 32'd40));
		send_item(make_item(16'd0, 1'b1, 1'b1, 32'd41));
	endtask

	task automatic test_random_traffic();
		int          p;
		logic [15:0] over;
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					over = 16'($urandom_range(20000, 60000));
					program_regs(over, 16'($urandom_range(1000, over / 2)),
						16'($urandom_range(0, 3000)), $urandom_range(0, 40));
					run_random_phase(100, 30);
				end
				1: begin
					program_regs(16'($urandom), 16'($urandom), 16'($urandom),
						$urandom_range(0, 20));
					run_random_phase(100, 15);
				end
				2: begin
					over = 16'($urandom_range(10000, 65000));
					program_regs(over, 16'($urandom_range(0, over)), 16'd0, 32'd0);
					run_random_phase(100, 5);
				end
				default: begin
					program_regs(RST_OVER_THRESHOLD, RST_UNDER_THRESHOLD, RST_HYSTERESIS,
						RST_RECOVER_DELAY);
					run_random_phase(100, 2000);
				end
			endcase
		end
	endtask

	task automatic test_no_idle_stretch();
		logic [15:0] over;
		over = 16'($urandom_range(20000, 60000));
		program_regs(over, 16'($urandom_range(1000, over / 2)),
			16'($urandom_range(0, 3000)), $urandom_range(0, 40));
		sender_idle_on = 1'b0;
		recv_idle_on   = 1'b0;
		run_random_phase(100, 30);
		sender_idle_on = 1'b1;
		recv_idle_on   = 1'b1;
	endtask

	// The receiver holds off while every transaction ends a batch, so the
	// result register stays full and the input backs up.
	task automatic test_backpressure();
		int k;
		wait_for_idle();
		stall_hold_left <= HOLD_CYCLES;
		for (k = 0; k < 20; k++)
			send_item(make_item(16'($urandom), 1'b1, 1'b1, $urandom));
		wait_for_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item            = '0;
		result_stall    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sender_idle_on  = 1'b1;
		recv_idle_on    = 1'b1;
		stall_hold_left = 0;
		mismatch_count  = 0;
		cfg_over        = RST_OVER_THRESHOLD;
		cfg_under       = RST_UNDER_THRESHOLD;
		cfg_hyst        = RST_HYSTERESIS;
		cfg_delay       = RST_RECOVER_DELAY;
		batch_sum       = '0;
		batch_count     = '0;
		avg_mv          = '0;
		fault_state     = STATUS_NORMAL;
		recover_wait    = 1'b0;
		recover_from    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_no_idle_stretch();
		test_backpressure();
		wait_for_idle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[bus_voltage_fault_monitor.f]
sv/bvfm_pkg.sv
sv/bvfm_ctrl.sv
sv/bvfm_dpath.sv
sv/bus_voltage_fault_monitor.sv
dv/bus_voltage_fault_monitor_test.sv
